// File: design/fts_pkg.sv
package fts_pkg;

    // token kinds
    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_NUMBER  = 5'd1;
    localparam logic [4:0] K_HOLL    = 5'd2;
    localparam logic [4:0] K_STRING  = 5'd3;
    localparam logic [4:0] K_BOZ     = 5'd4;
    localparam logic [4:0] K_LPSL    = 5'd5;
    localparam logic [4:0] K_SLRP    = 5'd6;
    localparam logic [4:0] K_LPAREN  = 5'd7;
    localparam logic [4:0] K_RPAREN  = 5'd8;
    localparam logic [4:0] K_LBRACK  = 5'd9;
    localparam logic [4:0] K_RBRACK  = 5'd10;
    localparam logic [4:0] K_COMMA   = 5'd11;
    localparam logic [4:0] K_DCOLON  = 5'd12;
    localparam logic [4:0] K_COLON   = 5'd13;
    localparam logic [4:0] K_SEMI    = 5'd14;
    localparam logic [4:0] K_PCT     = 5'd15;
    localparam logic [4:0] K_OPER    = 5'd16;
    localparam logic [4:0] K_INVALID = 5'd17;
    localparam logic [4:0] K_END     = 5'd18;

    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_DQ = 8'h22;

    // scanner modes; M_END and M_BAD are only decision results
    typedef enum logic [24:0] {
        M_IDLE      = 25'h0000001,
        M_IDENT     = 25'h0000002,
        M_PAIR      = 25'h0000004,
        M_DOT_A     = 25'h0000008,
        M_DOT_B     = 25'h0000010,
        M_DOT_C     = 25'h0000020,
        M_DOT_CLOSE = 25'h0000040,
        M_STR       = 25'h0000080,
        M_STR_ESC   = 25'h0000100,
        M_BOZ_Q     = 25'h0000200,
        M_BOZ_BODY  = 25'h0000400,
        M_LEAD      = 25'h0000800,
        M_LEADX     = 25'h0001000,
        M_DOTQ      = 25'h0002000,
        M_FRAC      = 25'h0004000,
        M_EXP_L     = 25'h0008000,
        M_EXP_S     = 25'h0010000,
        M_EXP_D     = 25'h0020000,
        M_KIND_U    = 25'h0040000,
        M_KIND_I    = 25'h0080000,
        M_FSUF      = 25'h0100000,
        M_HOLL_H    = 25'h0200000,
        M_HOLL_P    = 25'h0400000,
        M_END       = 25'h0800000,
        M_BAD       = 25'h1000000
    } t_mode;

    // one queued input item, classified by the front
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       is_nul;
    } t_item;

    // number step result: next mode and a kill of number validity
    typedef struct packed {
        t_mode mode;
        logic  kill;
    } t_nn;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ident_cont(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic op_char(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
               c == "<" || c == ">" || c == "~";
    endfunction

    function automatic logic two_char_op(logic [7:0] c, logic [7:0] a);
        return (c == "*" && a == "*") || (c == "/" && a == "/") ||
               (c == "/" && a == "=") || (c == "=" && a == "=") ||
               (c == "=" && a == ">") || (c == "<" && a == "=") ||
               (c == ">" && a == "=") || (c == "<" && a == ">");
    endfunction

    function automatic t_mode dot_next(t_mode phase, logic [7:0] x);
        t_mode m;
        if (x == ".") begin
            m = M_DOT_CLOSE;
        end else if (is_space(x)) begin
            m = (phase == M_DOT_A) ? M_DOT_A : M_DOT_C;
        end else if (is_alpha(x) && phase != M_DOT_C) begin
            m = M_DOT_B;
        end else begin
            m = M_BAD;
        end
        return m;
    endfunction

    function automatic t_mode f_check(logic [7:0] x);
        return (x == "f" || x == "F") ? M_FSUF : M_END;
    endfunction

    function automatic t_mode kind_check(logic [7:0] x);
        return (x == "_") ? M_KIND_U : f_check(x);
    endfunction

    function automatic t_mode exp_check(logic [7:0] x);
        logic [7:0] l;
        l = x | 8'h20;
        return (is_alpha(x) && (l == "e" || l == "d" || l == "q")) ? M_EXP_L
                                                                  : kind_check(x);
    endfunction

    // lookahead test after a digit string and a dot
    function automatic logic frac_ok(logic [7:0] n, logic [7:0] e, logic [7:0] s);
        logic r;
        if (!is_alpha(n)) begin
            r = 1'b1;
        end else if (n == "e" || n == "E" || n == "d" || n == "D") begin
            r = is_digit(e) || ((e == "+" || e == "-") && is_digit(s));
        end else begin
            r = (n == "f" || n == "F") && !ident_cont(e);
        end
        return r;
    endfunction

    function automatic t_nn num_next(t_mode mode, logic [7:0] x);
        t_nn r;
        r.kill = 1'b0;
        r.mode = M_END;
        case (mode)
            M_LEAD: begin
                if (is_digit(x)) r.mode = M_LEAD;
                else if (x == "h" || x == "H") r.mode = M_HOLL_H;
                else if (x == ".") r.mode = M_DOTQ;
                else r.mode = exp_check(x);
            end
            M_LEADX: begin
                if (is_digit(x)) r.mode = M_LEADX;
                else if (x == ".") r.mode = M_DOTQ;
                else r.mode = exp_check(x);
            end
            M_FRAC: r.mode = is_digit(x) ? M_FRAC : exp_check(x);
            M_EXP_L: begin
                if (x == "+" || x == "-") r.mode = M_EXP_S;
                else if (is_digit(x)) r.mode = M_EXP_D;
                else begin
                    r.kill = 1'b1;
                    r.mode = kind_check(x);
                end
            end
            M_EXP_S: begin
                if (is_digit(x)) r.mode = M_EXP_D;
                else begin
                    r.kill = 1'b1;
                    r.mode = kind_check(x);
                end
            end
            M_EXP_D: r.mode = is_digit(x) ? M_EXP_D : kind_check(x);
            M_KIND_U: begin
                if (ident_cont(x)) r.mode = M_KIND_I;
                else begin
                    r.kill = 1'b1;
                    r.mode = f_check(x);
                end
            end
            M_KIND_I: r.mode = ident_cont(x) ? M_KIND_I : f_check(x);
            default: r.mode = M_END;
        endcase
        return r;
    endfunction

endpackage

// File: design/fts_front.sv
module fts_front import fts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_is_line_end,
    output t_item      o_item,
    output logic       o_item_valid,
    input  logic       i_pop
);

    logic [7:0] r_q_ch  [4];
    logic       r_q_end [4];
    logic       r_q_nul [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       w_push;

    assign o_ready      = (r_count != 3'd4);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != 3'd0);

    // head of queue
    assign o_item.ch     = r_q_ch[r_rp];
    assign o_item.is_end = r_q_end[r_rp];
    assign o_item.is_nul = r_q_nul[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_count <= r_count + {2'b00, w_push} - {2'b00, i_pop};
        end
    end

    // classify and store each transfer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_ch[r_wp]  <= i_char_code;
            r_q_end[r_wp] <= i_is_line_end;
            r_q_nul[r_wp] <= !i_is_line_end && (i_char_code == 8'd0);
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 3'd0))
        else $error("pop from empty queue");
`endif

endmodule

// File: design/fts_back.sv
module fts_back import fts_pkg::*; #(
    parameter int MAX_LINE             = 1024,
    parameter int HOLLERITH_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_kind,
    output logic [10:0] o_start,
    output logic [10:0] o_len,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int HW = HOLLERITH_COUNT_BITS + 1;
    localparam logic [HW-1:0] HOLL_MAX = {1'b0, {HOLLERITH_COUNT_BITS{1'b1}}};
    localparam logic [HW-1:0] HOLL_OVF = {1'b1, {HOLLERITH_COUNT_BITS{1'b0}}};
    localparam logic [CW-1:0] LINE_MAX = CW'(MAX_LINE);

    typedef enum logic [2:0] {
        B_NEW   = 3'b001,
        B_HEAD  = 3'b010,
        B_FLUSH = 3'b100
    } t_bstate;

    t_bstate       r_bstate, n_bstate;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_tok_start, n_tok_start;
    logic [CW-1:0] r_lp, n_lp;
    logic [7:0]    r_win [4];
    logic [7:0]    n_win [4];
    logic [2:0]    r_cnt, n_cnt;
    logic [HW-1:0] r_holl, n_holl;
    logic [7:0]    r_quote, n_quote;
    logic          r_nv, n_nv;
    logic          r_drop, n_drop;
    logic [4:0]    r_pair, n_pair;
    logic [2:0]    r_ecnt, n_ecnt;
    logic          r_ov, n_ov;
    logic [4:0]    r_okind, n_okind;
    logic [10:0]   r_ostart, n_ostart;
    logic [10:0]   r_olen, n_olen;
    logic          r_olast, n_olast;

    assign o_valid = r_ov;
    assign o_kind  = r_okind;
    assign o_start = r_ostart;
    assign o_len   = r_olen;
    assign o_last  = r_olast;

    // engine: one head decision or one line close per cycle unless stalled
    always_comb begin
        logic [7:0]    w [4];
        logic [2:0]    cnt_e;
        logic [CW-1:0] lp_e;
        logic          go, do_head, do_final, done, flush_ctx, consume, kill_win;
        logic [7:0]    c, a0, a1, a2, lc;
        logic [CW-1:0] col, len, ts;
        logic          fin;
        logic [4:0]    fin_kind;
        logic [CW-1:0] fin_len;
        logic          e_v, e_last;
        logic [4:0]    e_kind;
        logic [CW-1:0] e_start, e_len;
        logic          nv_e, apply;
        t_nn           nn;
        t_mode         dm;
        logic [HW+3:0] hx;
        logic [HW-1:0] hd;
        logic [2:0]    ebase;
        logic [CW:0]   endcol;

        n_bstate    = r_bstate;
        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_lp        = r_lp;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_holl      = r_holl;
        n_quote     = r_quote;
        n_nv        = r_nv;
        n_drop      = r_drop;
        n_pair      = r_pair;
        n_ecnt      = r_ecnt;
        n_ov        = r_ov && !i_ready;
        n_okind     = r_okind;
        n_ostart    = r_ostart;
        n_olen      = r_olen;
        n_olast     = r_olast;
        o_pop       = 1'b0;

        w         = r_win;
        cnt_e     = r_cnt;
        lp_e      = r_lp;
        do_head   = 1'b0;
        do_final  = 1'b0;
        done      = 1'b0;
        flush_ctx = 1'b0;
        consume   = 1'b1;
        kill_win  = 1'b0;
        fin       = 1'b0;
        fin_kind  = K_INVALID;
        fin_len   = '0;
        e_v       = 1'b0;
        e_last    = 1'b0;
        e_kind    = K_END;
        e_start   = '0;
        e_len     = '0;
        nv_e      = r_nv;
        apply     = 1'b0;
        nn        = '{mode: M_END, kill: 1'b0};
        dm        = M_BAD;
        hx        = '0;
        hd        = '0;
        lc        = 8'd0;
        endcol    = '0;
        ebase     = (r_bstate == B_NEW) ? 3'd0 : r_ecnt;
        go        = i_item_valid && (!r_ov || i_ready);

        // choose the work of this cycle
        if (go) begin
            unique case (r_bstate)
                B_NEW: begin
                    if (i_item.is_end) begin
                        flush_ctx = 1'b1;
                        if (r_cnt != 3'd0) do_head = 1'b1;
                        else do_final = 1'b1;
                    end else if (r_lp >= LINE_MAX) begin
                        done = 1'b1;
                    end else if (r_drop) begin
                        n_lp = r_lp + 1'b1;
                        done = 1'b1;
                    end else if (i_item.is_nul) begin
                        flush_ctx = 1'b1;
                        if (r_cnt != 3'd0) do_head = 1'b1;
                        else do_final = 1'b1;
                    end else begin
                        w[r_cnt[1:0]] = i_item.ch;
                        cnt_e = r_cnt + 3'd1;
                        lp_e  = r_lp + 1'b1;
                        n_win = w;
                        n_cnt = cnt_e;
                        n_lp  = lp_e;
                        if (cnt_e == 3'd4) do_head = 1'b1;
                        else done = 1'b1;
                    end
                end
                B_HEAD: do_head = 1'b1;
                B_FLUSH: begin
                    flush_ctx = 1'b1;
                    if (r_cnt != 3'd0) do_head = 1'b1;
                    else do_final = 1'b1;
                end
                default: done = 1'b1;
            endcase
        end

        // decide the oldest pending character
        c   = w[0];
        a0  = (cnt_e > 3'd1) ? w[1] : 8'd0;
        a1  = (cnt_e > 3'd2) ? w[2] : 8'd0;
        a2  = (cnt_e > 3'd3) ? w[3] : 8'd0;
        col = lp_e - CW'(cnt_e) + 1'b1;
        ts  = r_tok_start;
        len = col - ts + 1'b1;

        if (do_head) begin
            unique case (r_mode) inside
                M_IDLE: begin
                    n_tok_start = col;
                    ts = col;
                    if (is_space(c) || c == 8'd0) begin
                        // nothing to start
                    end else if (c == "!") begin
                        n_drop   = 1'b1;
                        kill_win = 1'b1;
                    end else if (is_alpha(c) || c == "_") begin
                        lc = c | 8'h20;
                        if ((lc == "b" || lc == "o" || lc == "z" || lc == "x") &&
                            (a0 == CH_SQ || a0 == CH_DQ)) begin
                            n_quote = a0;
                            n_mode  = M_BOZ_Q;
                        end else if (ident_cont(a0)) begin
                            n_mode = M_IDENT;
                        end else begin
                            fin = 1'b1; fin_kind = K_IDENT; fin_len = CW'(1);
                        end
                    end else if (is_digit(c)) begin
                        nv_e   = 1'b1;
                        n_holl = HW'(c[3:0]);
                        nn     = num_next(M_LEAD, a0);
                        apply  = 1'b1;
                    end else if (c == "." && is_digit(a0)) begin
                        n_nv   = 1'b1;
                        n_holl = '0;
                        n_mode = M_LEADX;
                    end else if (c == CH_SQ || c == CH_DQ) begin
                        n_quote = c;
                        if (a0 == 8'd0) begin
                            fin = 1'b1; fin_kind = K_INVALID; fin_len = CW'(1);
                        end else begin
                            n_mode = M_STR;
                        end
                    end else if (c == "(") begin
                        if (a0 == "/") begin
                            n_pair = K_LPSL; n_mode = M_PAIR;
                        end else begin
                            fin = 1'b1; fin_kind = K_LPAREN; fin_len = CW'(1);
                        end
                    end else if (c == "/" && a0 == ")") begin
                        n_pair = K_SLRP; n_mode = M_PAIR;
                    end else if (c == ")") begin
                        fin = 1'b1; fin_kind = K_RPAREN; fin_len = CW'(1);
                    end else if (c == "[") begin
                        fin = 1'b1; fin_kind = K_LBRACK; fin_len = CW'(1);
                    end else if (c == "]") begin
                        fin = 1'b1; fin_kind = K_RBRACK; fin_len = CW'(1);
                    end else if (c == ",") begin
                        fin = 1'b1; fin_kind = K_COMMA; fin_len = CW'(1);
                    end else if (c == ":") begin
                        if (a0 == ":") begin
                            n_pair = K_DCOLON; n_mode = M_PAIR;
                        end else begin
                            fin = 1'b1; fin_kind = K_COLON; fin_len = CW'(1);
                        end
                    end else if (c == ";") begin
                        fin = 1'b1; fin_kind = K_SEMI; fin_len = CW'(1);
                    end else if (c == "%") begin
                        fin = 1'b1; fin_kind = K_PCT; fin_len = CW'(1);
                    end else if (c == ".") begin
                        dm = dot_next(M_DOT_A, a0);
                        if (dm == M_BAD) begin
                            fin = 1'b1; fin_kind = K_INVALID; fin_len = CW'(1);
                        end else begin
                            n_mode = dm;
                        end
                    end else if (op_char(c)) begin
                        if (two_char_op(c, a0)) begin
                            n_pair = K_OPER; n_mode = M_PAIR;
                        end else begin
                            fin = 1'b1; fin_kind = K_OPER; fin_len = CW'(1);
                        end
                    end else begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = CW'(1);
                    end
                end
                M_IDENT: begin
                    if (!ident_cont(a0)) begin
                        fin = 1'b1; fin_kind = K_IDENT; fin_len = len;
                    end
                end
                M_PAIR: begin
                    fin = 1'b1; fin_kind = r_pair; fin_len = len;
                end
                M_DOT_A, M_DOT_B, M_DOT_C: begin
                    dm = dot_next(r_mode, a0);
                    if (dm == M_BAD) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end else begin
                        n_mode = dm;
                    end
                end
                M_DOT_CLOSE: begin
                    fin = 1'b1; fin_kind = K_OPER; fin_len = len;
                end
                M_STR: begin
                    if (c == r_quote) begin
                        if (a0 == r_quote) begin
                            n_mode = M_STR_ESC;
                        end else begin
                            fin = 1'b1; fin_kind = K_STRING; fin_len = len;
                        end
                    end else if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end
                end
                M_STR_ESC: begin
                    if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end else begin
                        n_mode = M_STR;
                    end
                end
                M_BOZ_Q: begin
                    if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end else begin
                        n_mode = M_BOZ_BODY;
                    end
                end
                M_BOZ_BODY: begin
                    if (c == r_quote) begin
                        fin = 1'b1; fin_kind = K_BOZ; fin_len = len;
                    end else if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end
                end
                M_HOLL_H: begin
                    if (r_holl > HOLL_MAX) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end else if (r_holl == '0) begin
                        fin = 1'b1; fin_kind = K_HOLL; fin_len = len;
                    end else if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end else begin
                        n_mode = M_HOLL_P;
                    end
                end
                M_HOLL_P: begin
                    hd     = r_holl - 1'b1;
                    n_holl = hd;
                    if (hd == '0) begin
                        fin = 1'b1; fin_kind = K_HOLL; fin_len = len;
                    end else if (a0 == 8'd0) begin
                        fin = 1'b1; fin_kind = K_INVALID; fin_len = len;
                    end
                end
                M_LEAD: begin
                    // count times ten plus digit, saturating as an overflow mark
                    hx = (HW+4)'({r_holl, 3'b000}) + (HW+4)'({r_holl, 1'b0}) +
                         (HW+4)'(c[3:0]);
                    n_holl = (hx > (HW+4)'(HOLL_MAX)) ? HOLL_OVF : hx[HW-1:0];
                    nn     = num_next(M_LEAD, a0);
                    apply  = 1'b1;
                end
                M_DOTQ: begin
                    if (frac_ok(a0, a1, a2)) begin
                        nn    = num_next(M_FRAC, a0);
                        apply = 1'b1;
                    end else begin
                        // close the number before the dot; the dot is rescanned
                        fin      = 1'b1;
                        fin_kind = r_nv ? K_NUMBER : K_INVALID;
                        fin_len  = col - ts;
                        consume  = 1'b0;
                    end
                end
                default: begin
                    nn    = num_next(r_mode, a0);
                    apply = 1'b1;
                end
            endcase

            // number step result
            if (apply) begin
                nv_e = nv_e && !nn.kill;
                n_nv = nv_e;
                if (nn.mode == M_END) begin
                    fin      = 1'b1;
                    fin_kind = nv_e ? K_NUMBER : K_INVALID;
                    fin_len  = col - ts + 1'b1;
                end else begin
                    n_mode = nn.mode;
                end
            end

            // retire the head character
            if (consume) begin
                n_win[0] = w[1];
                n_win[1] = w[2];
                n_win[2] = w[3];
                n_win[3] = 8'd0;
                n_cnt    = cnt_e - 3'd1;
            end else begin
                n_win = w;
                n_cnt = cnt_e;
            end

            if (fin) begin
                e_v     = 1'b1;
                e_kind  = fin_kind;
                e_start = ts;
                e_len   = fin_len;
                n_mode  = M_IDLE;
                if (fin_kind == K_INVALID) begin
                    n_drop = 1'b1;
                    n_cnt  = 3'd0;
                end
            end
            if (kill_win) n_cnt = 3'd0;

            if (flush_ctx) begin
                n_bstate = B_FLUSH;
            end else if (n_cnt == 3'd4) begin
                n_bstate = B_HEAD;
            end else begin
                done = 1'b1;
            end
        end

        // close the line, or the text after a null character
        if (do_final) begin
            done = 1'b1;
            if (i_item.is_end) begin
                endcol = {1'b0, r_lp} + 1'b1;
                if (endcol > {1'b0, LINE_MAX}) endcol = {1'b0, LINE_MAX};
                e_v         = 1'b1;
                e_kind      = K_END;
                e_start     = endcol[CW-1:0];
                e_len       = '0;
                e_last      = 1'b1;
                n_mode      = M_IDLE;
                n_tok_start = '0;
                n_lp        = '0;
                n_cnt       = 3'd0;
                n_holl      = '0;
                n_quote     = 8'd0;
                n_nv        = 1'b1;
                n_drop      = 1'b0;
                n_pair      = K_IDENT;
            end else begin
                n_drop = 1'b1;
                n_cnt  = 3'd0;
                n_lp   = r_lp + 1'b1;
            end
        end

        // result transfer into the output register, at most four per item
        if (go) begin
            n_ecnt = ebase;
            if (e_v && ebase < 3'd4) begin
                n_ecnt   = ebase + 3'd1;
                n_ov     = 1'b1;
                n_okind  = e_kind;
                n_ostart = 11'(32'(e_start));
                n_olen   = 11'(32'(e_len));
                n_olast  = e_last;
            end
        end

        if (done) begin
            o_pop    = 1'b1;
            n_bstate = B_NEW;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= B_NEW;
            r_mode      <= M_IDLE;
            r_tok_start <= '0;
            r_lp        <= '0;
            r_cnt       <= 3'd0;
            r_holl      <= '0;
            r_quote     <= 8'd0;
            r_nv        <= 1'b1;
            r_drop      <= 1'b0;
            r_pair      <= K_IDENT;
            r_ecnt      <= 3'd0;
            r_ov        <= 1'b0;
        end else begin
            r_bstate    <= n_bstate;
            r_mode      <= n_mode;
            r_tok_start <= n_tok_start;
            r_lp        <= n_lp;
            r_cnt       <= n_cnt;
            r_holl      <= n_holl;
            r_quote     <= n_quote;
            r_nv        <= n_nv;
            r_drop      <= n_drop;
            r_pair      <= n_pair;
            r_ecnt      <= n_ecnt;
            r_ov        <= n_ov;
        end
    end

    // window characters and result payload
    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_okind  <= n_okind;
        r_ostart <= n_ostart;
        r_olen   <= n_olen;
        r_olast  <= n_olast;
    end

`ifndef SYNTHESIS
    a_win_between_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == B_NEW) |-> (r_cnt <= 3'd3))
        else $error("lookahead window over-full between items");
    a_emit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= 3'd4)
        else $error("per-item result count beyond four");
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_olast == (r_okind == K_END)))
        else $error("last flag not matching end marker");
`endif

endmodule

// File: design/fortran_token_scanner.sv
// Fortran line token scanner. Characters of one line go in one per transfer,
// closed by a transfer with is_line_end set; tokens come out as kind, start
// column and length, followed by an end marker with is_last set. A 4-entry
// input queue parts the input from the scanning engine, and a result register
// parts the engine from the output. The engine makes one lookahead decision
// per cycle while an item waits and the result register is free. A token is
// released when the third character after its end has arrived. A number that
// stops in front of a '.' that is not its fraction is closed without taking
// the dot, which is then scanned again. A line end or a null first decides
// each pending character (at most three, plus such rescans), then closes the
// line or, after a null, drops its rest. Results leave at most one per cycle.
module fortran_token_scanner import fts_pkg::*; #(
    parameter int MAX_LINE             = 1024,
    parameter int HOLLERITH_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_line_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [10:0] o_start_column,
    output logic [10:0] o_token_length,
    output logic        o_is_last
);

    t_item w_item;
    logic  w_item_valid;
    logic  w_pop;

    // input queue
    fts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_is_line_end (i_is_line_end),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_pop         (w_pop)
    );

    // scanning engine
    fts_back #(
        .MAX_LINE             (MAX_LINE),
        .HOLLERITH_COUNT_BITS (HOLLERITH_COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_token_kind),
        .o_start      (o_start_column),
        .o_len        (o_token_length),
        .o_last       (o_is_last)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fts_pkg::*;

    localparam int          LINE_MAX  = 1024;
    localparam longint      HCNT_MAX  = 65535;
    localparam int          END_WAIT  = 60;

    // scanner phases of the predictor
    localparam int ST_WAIT = 0,  ST_WORD = 1,  ST_TWO = 2,   ST_DOT1 = 3,  ST_DOT2 = 4;
    localparam int ST_DOT3 = 5,  ST_DOTEND = 6, ST_QUOTE = 7, ST_QQ = 8,   ST_BOZQ = 9;
    localparam int ST_BOZ = 10,  ST_INT = 11,  ST_INTX = 12, ST_PT = 13,   ST_FRAC = 14;
    localparam int ST_EXPL = 15, ST_EXPS = 16, ST_EXPD = 17, ST_KINDU = 18, ST_KINDI = 19;
    localparam int ST_FSUF = 20, ST_HH = 21,   ST_HP = 22,   ST_DONE = 23, ST_FAIL = 24;

    typedef struct {
        logic [4:0]  kind;
        logic [10:0] col;
        logic [10:0] len;
        logic        last;
    } t_token;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_is_line_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_token_kind;
    logic [10:0] o_start_column;
    logic [10:0] o_token_length;
    logic        o_is_last;

    fortran_token_scanner i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_char_code(i_char_code), .i_is_line_end(i_is_line_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_token_kind(o_token_kind), .o_start_column(o_start_column),
        .o_token_length(o_token_length), .o_is_last(o_is_last)
    );

    t_char_item  src_chars[$];
    t_token      tokens_due[$];
    int          errors = 0;
    int          chars_sent = 0;
    int          tokens_seen = 0;
    int          lines_built = 0;

    // scanner state mirror
    int              sc_phase;
    int unsigned     sc_start;
    int unsigned     sc_pos;
    logic [7:0]      sc_win[4];
    int unsigned     sc_cnt;
    longint unsigned sc_holl;
    logic [7:0]      sc_quote;
    bit              sc_numok;
    bit              sc_drop;
    logic [4:0]      sc_pair;
    int              step_tokens;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_sp(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit is_al(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit is_dg(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit is_wc(logic [7:0] c);
        return is_al(c) || is_dg(c) || c == "_";
    endfunction
    function automatic bit is_opc(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
               c == "<" || c == ">" || c == "~";
    endfunction
    function automatic bit is_pair_op(logic [7:0] c, logic [7:0] a);
        return (c == "*" && a == "*") || (c == "/" && (a == "/" || a == "=")) ||
               (c == "=" && (a == "=" || a == ">")) || (c == "<" && (a == "=" || a == ">")) ||
               (c == ">" && a == "=");
    endfunction

    function automatic void queue_token(logic [4:0] k, int unsigned s, int unsigned l, bit last);
        t_token t;
        if (step_tokens >= 4) return;
        t.kind = k;
        t.col = s[10:0];
        t.len = l[10:0];
        t.last = last;
        tokens_due.push_back(t);
        step_tokens++;
    endfunction

    function automatic void close_token(logic [4:0] k, int unsigned l);
        queue_token(k, sc_start, l, 1'b0);
        sc_phase = ST_WAIT;
        if (k == K_INVALID) begin
            sc_drop = 1'b1;
            sc_cnt = 0;
        end
    endfunction

    function automatic int dot_step(int ph, logic [7:0] x);
        if (x == ".") return ST_DOTEND;
        if (is_sp(x)) return (ph == ST_DOT1) ? ST_DOT1 : ST_DOT3;
        if (is_al(x) && ph != ST_DOT3) return ST_DOT2;
        return ST_FAIL;
    endfunction

    function automatic int after_kind(logic [7:0] x);
        return (x == "f" || x == "F") ? ST_FSUF : ST_DONE;
    endfunction
    function automatic int after_exp(logic [7:0] x);
        return (x == "_") ? ST_KINDU : after_kind(x);
    endfunction
    function automatic int after_mant(logic [7:0] x);
        logic [7:0] l;
        l = x | 8'h20;
        if (is_al(x) && (l == "e" || l == "d" || l == "q")) return ST_EXPL;
        return after_exp(x);
    endfunction

    // next number phase; malformed exponent or kind clears validity
    function automatic int num_step(int ph, logic [7:0] x);
        case (ph)
            ST_INT: begin
                if (is_dg(x)) return ST_INT;
                if (x == "h" || x == "H") return ST_HH;
                if (x == ".") return ST_PT;
                return after_mant(x);
            end
            ST_INTX: begin
                if (is_dg(x)) return ST_INTX;
                if (x == ".") return ST_PT;
                return after_mant(x);
            end
            ST_FRAC: return is_dg(x) ? ST_FRAC : after_mant(x);
            ST_EXPL: begin
                if (x == "+" || x == "-") return ST_EXPS;
                if (is_dg(x)) return ST_EXPD;
                sc_numok = 1'b0;
                return after_exp(x);
            end
            ST_EXPS: begin
                if (is_dg(x)) return ST_EXPD;
                sc_numok = 1'b0;
                return after_exp(x);
            end
            ST_EXPD: return is_dg(x) ? ST_EXPD : after_exp(x);
            ST_KINDU: begin
                if (is_wc(x)) return ST_KINDI;
                sc_numok = 1'b0;
                return after_kind(x);
            end
            ST_KINDI: return is_wc(x) ? ST_KINDI : after_kind(x);
            default: return ST_DONE;
        endcase
    endfunction

    function automatic void num_go(int ph, int unsigned col);
        if (ph == ST_DONE) close_token(sc_numok ? K_NUMBER : K_INVALID, col - sc_start + 1);
        else sc_phase = ph;
    endfunction

    // lookahead after digits and a dot: is the dot the fraction point
    function automatic bit frac_here(logic [7:0] n, logic [7:0] e, logic [7:0] s);
        if (!is_al(n)) return 1'b1;
        if (n == "e" || n == "E" || n == "d" || n == "D")
            return is_dg(e) || ((e == "+" || e == "-") && is_dg(s));
        return (n == "f" || n == "F") && !is_wc(e);
    endfunction

    function automatic void two_or_one(bit two, logic [4:0] k2, logic [4:0] k1);
        if (two) begin
            sc_pair = k2;
            sc_phase = ST_TWO;
        end else begin
            close_token(k1, 1);
        end
    endfunction

    function automatic void open_token(logic [7:0] c, logic [7:0] a0, int unsigned col);
        logic [7:0] l;
        int ph;
        sc_start = col;
        l = c | 8'h20;
        if (is_sp(c) || c == 8'd0) return;
        if (c == "!") begin
            sc_drop = 1'b1;
            sc_cnt = 0;
        end else if (is_al(c) || c == "_") begin
            if ((l == "b" || l == "o" || l == "z" || l == "x") && (a0 == CH_SQ || a0 == CH_DQ)) begin
                sc_quote = a0;
                sc_phase = ST_BOZQ;
            end else if (is_wc(a0)) begin
                sc_phase = ST_WORD;
            end else begin
                close_token(K_IDENT, 1);
            end
        end else if (is_dg(c)) begin
            sc_numok = 1'b1;
            sc_holl = longint'(c) - 48;
            num_go(num_step(ST_INT, a0), col);
        end else if (c == "." && is_dg(a0)) begin
            sc_numok = 1'b1;
            sc_holl = 0;
            sc_phase = ST_INTX;
        end else if (c == CH_SQ || c == CH_DQ) begin
            sc_quote = c;
            if (a0 == 8'd0) close_token(K_INVALID, 1);
            else sc_phase = ST_QUOTE;
        end else if (c == "(") two_or_one(a0 == "/", K_LPSL, K_LPAREN);
        else if (c == "/" && a0 == ")") two_or_one(1'b1, K_SLRP, K_SLRP);
        else if (c == ")") close_token(K_RPAREN, 1);
        else if (c == "[") close_token(K_LBRACK, 1);
        else if (c == "]") close_token(K_RBRACK, 1);
        else if (c == ",") close_token(K_COMMA, 1);
        else if (c == ":") two_or_one(a0 == ":", K_DCOLON, K_COLON);
        else if (c == ";") close_token(K_SEMI, 1);
        else if (c == "%") close_token(K_PCT, 1);
        else if (c == ".") begin
            ph = dot_step(ST_DOT1, a0);
            if (ph == ST_FAIL) close_token(K_INVALID, 1);
            else sc_phase = ph;
        end else if (is_opc(c)) two_or_one(is_pair_op(c, a0), K_OPER, K_OPER);
        else close_token(K_INVALID, 1);
    endfunction

    // decide the oldest waiting character
    function automatic void decide_head();
        logic [7:0] c, a0, a1, a2;
        int unsigned col, len;
        int ph;
        c = sc_win[0];
        a0 = (sc_cnt > 1) ? sc_win[1] : 8'd0;
        a1 = (sc_cnt > 2) ? sc_win[2] : 8'd0;
        a2 = (sc_cnt > 3) ? sc_win[3] : 8'd0;
        col = sc_pos - sc_cnt + 1;
        sc_win[0] = sc_win[1];
        sc_win[1] = sc_win[2];
        sc_win[2] = sc_win[3];
        sc_win[3] = 8'd0;
        sc_cnt--;
        len = col - sc_start + 1;
        case (sc_phase)
            ST_WAIT: open_token(c, a0, col);
            ST_WORD: if (!is_wc(a0)) close_token(K_IDENT, len);
            ST_TWO: close_token(sc_pair, len);
            ST_DOT1, ST_DOT2, ST_DOT3: begin
                ph = dot_step(sc_phase, a0);
                if (ph == ST_FAIL) close_token(K_INVALID, len);
                else sc_phase = ph;
            end
            ST_DOTEND: close_token(K_OPER, len);
            ST_QUOTE: begin
                if (c == sc_quote) begin
                    if (a0 == sc_quote) sc_phase = ST_QQ;
                    else close_token(K_STRING, len);
                end else if (a0 == 8'd0) close_token(K_INVALID, len);
            end
            ST_QQ: begin
                if (a0 == 8'd0) close_token(K_INVALID, len);
                else sc_phase = ST_QUOTE;
            end
            ST_BOZQ: begin
                if (a0 == 8'd0) close_token(K_INVALID, len);
                else sc_phase = ST_BOZ;
            end
            ST_BOZ: begin
                if (c == sc_quote) close_token(K_BOZ, len);
                else if (a0 == 8'd0) close_token(K_INVALID, len);
            end
            ST_HH: begin
                if (sc_holl > HCNT_MAX) close_token(K_INVALID, len);
                else if (sc_holl == 0) close_token(K_HOLL, len);
                else if (a0 == 8'd0) close_token(K_INVALID, len);
                else sc_phase = ST_HP;
            end
            ST_HP: begin
                sc_holl--;
                if (sc_holl == 0) close_token(K_HOLL, len);
                else if (a0 == 8'd0) close_token(K_INVALID, len);
            end
            ST_INT: begin
                sc_holl = sc_holl * 10 + (longint'(c) - 48);
                if (sc_holl > HCNT_MAX) sc_holl = HCNT_MAX + 1;
                num_go(num_step(ST_INT, a0), col);
            end
            ST_PT: begin
                if (frac_here(a0, a1, a2)) begin
                    num_go(num_step(ST_FRAC, a0), col);
                end else begin
                    close_token(sc_numok ? K_NUMBER : K_INVALID, col - sc_start);
                    if (!sc_drop) open_token(c, a0, col);
                end
            end
            default: num_go(num_step(sc_phase, a0), col);
        endcase
    endfunction

    function automatic void clear_scan();
        sc_phase = ST_WAIT;
        sc_start = 0;
        sc_pos = 0;
        for (int k = 0; k < 4; k++) sc_win[k] = 8'd0;
        sc_cnt = 0;
        sc_holl = 0;
        sc_quote = 8'd0;
        sc_numok = 1'b1;
        sc_drop = 1'b0;
        sc_pair = 5'd0;
    endfunction

    // expected tokens caused by one accepted character or line end
    function automatic void scan_char(logic [7:0] c, bit eol);
        int unsigned endcol;
        step_tokens = 0;
        if (eol) begin
            endcol = sc_pos + 1;
            while (sc_cnt > 0) decide_head();
            if (endcol > LINE_MAX) endcol = LINE_MAX;
            queue_token(K_END, endcol, 0, 1'b1);
            clear_scan();
        end else if (sc_pos >= LINE_MAX) begin
        end else if (sc_drop) begin
            sc_pos++;
        end else if (c == 8'd0) begin
            while (sc_cnt > 0) decide_head();
            sc_drop = 1'b1;
            sc_cnt = 0;
            sc_pos++;
        end else begin
            sc_win[sc_cnt & 3] = c;
            sc_cnt++;
            sc_pos++;
            if (sc_cnt >= 4) decide_head();
        end
    endfunction

    // stimulus building
    function automatic void put_ch(logic [7:0] c);
        t_char_item it;
        it.ch = c;
        it.eol = 1'b0;
        src_chars.push_back(it);
    endfunction

    function automatic void put_str(string s);
        for (int k = 0; k < s.len(); k++) put_ch(s[k]);
    endfunction

    function automatic void put_eol();
        t_char_item it;
        it.ch = 8'($urandom);
        it.eol = 1'b1;
        src_chars.push_back(it);
        lines_built++;
    endfunction

    function automatic void put_line(string s);
        put_str(s);
        put_eol();
    endfunction

    function automatic logic [7:0] rnd_letter();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(97, 122))
                                           : 8'($urandom_range(65, 90));
    endfunction
    function automatic logic [7:0] rnd_digit();
        return 8'($urandom_range(48, 57));
    endfunction
    function automatic logic [7:0] rnd_word_ch();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return rnd_letter();
        if (r < 9) return rnd_digit();
        return "_";
    endfunction

    // one lexeme with random content, sometimes malformed
    function automatic void put_lexeme();
        int n;
        logic [7:0] q;
        string ops[22] = '{"+", "-", "*", "/", "=", "<", ">", "~", "**", "//", "/=", "==",
                            "=>", "<=", ">=", "<>", "(/", "/)", "::", ":", ";", "%"};
        string exp_letters = "eEdDqQ";
        string boz_letters = "bBoOzZxX";
        string punct_chars = "()[],";
        case ($urandom_range(0, 11))
            0, 1: begin
                put_ch(($urandom_range(0, 7) == 0) ? "_" : rnd_letter());
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) put_ch(rnd_word_ch());
            end
            2, 3: begin
                if ($urandom_range(0, 5) == 0) put_ch(".");
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) put_ch(rnd_digit());
                if ($urandom_range(0, 1) != 0) begin
                    put_ch(".");
                    n = $urandom_range(0, 3);
                    for (int k = 0; k < n; k++) put_ch(rnd_digit());
                end
                if ($urandom_range(0, 2) == 0) begin
                    put_ch(exp_letters[$urandom_range(0, 5)]);
                    if ($urandom_range(0, 1) != 0) put_ch(($urandom_range(0, 1) != 0) ? "+" : "-");
                    n = $urandom_range(0, 2);
                    for (int k = 0; k < n; k++) put_ch(rnd_digit());
                end
                if ($urandom_range(0, 3) == 0) begin
                    put_ch("_");
                    n = $urandom_range(0, 2);
                    for (int k = 0; k < n; k++) put_ch(rnd_word_ch());
                end
                if ($urandom_range(0, 5) == 0) put_ch("f");
            end
            4: begin
                n = $urandom_range(0, 6);
                put_str($sformatf("%0d", n));
                put_ch(($urandom_range(0, 1) != 0) ? "H" : "h");
                if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
                for (int k = 0; k < n; k++) put_ch(8'($urandom_range(32, 126)));
            end
            5: begin
                q = ($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ;
                put_ch(q);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        put_ch(q);
                        put_ch(q);
                    end else begin
                        put_ch(8'($urandom_range(32, 126)));
                    end
                end
                if ($urandom_range(0, 7) != 0) put_ch(q);
            end
            6: begin
                put_ch(boz_letters[$urandom_range(0, 7)]);
                q = ($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ;
                put_ch(q);
                n = $urandom_range(0, 5);
                for (int k = 0; k < n; k++) put_ch(($urandom_range(0, 1) != 0) ? rnd_digit()
                                                                              : rnd_letter());
                if ($urandom_range(0, 7) != 0) put_ch(q);
            end
            7: begin
                put_ch(".");
                if ($urandom_range(0, 3) == 0) put_ch(" ");
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) put_ch(rnd_letter());
                if ($urandom_range(0, 3) == 0) put_ch(" ");
                if ($urandom_range(0, 7) != 0) put_ch(".");
            end
            8, 9: put_str(ops[$urandom_range(0, 21)]);
            10: put_ch(punct_chars[$urandom_range(0, 4)]);
            default: begin
                n = $urandom_range(0, 19);
                if (n == 0) put_ch("!");
                else if (n == 1) put_ch(8'd0);
                else put_ch(8'($urandom_range(1, 255)));
            end
        endcase
    endfunction

    function automatic void put_random_line();
        int n;
        if ($urandom_range(0, 99) < 85) begin
            n = $urandom_range(1, 7);
            for (int k = 0; k < n; k++) begin
                put_lexeme();
                case ($urandom_range(0, 5))
                    0, 1: put_ch(" ");
                    2: put_ch(8'($urandom_range(9, 13)));
                    default: ;
                endcase
            end
        end else begin
            n = $urandom_range(0, 12);
            for (int k = 0; k < n; k++)
                put_ch(($urandom_range(0, 30) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        end
        put_eol();
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // driver: one transfer per accepted character, random gaps in between
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_char_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                scan_char(i_char_code, i_is_line_end);
                chars_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || src_chars.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    it = src_chars.pop_front();
                    i_char_code <= it.ch;
                    i_is_line_end <= it.eol;
                    i_valid <= 1'b1;
                    if ((chars_sent / 120) % 3 == 1) gap_left = 0;
                    else if ($urandom_range(0, 49) == 0) gap_left = $urandom_range(10, 40);
                    else if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 3);
                    else gap_left = 0;
                end
            end
        end
    end

    // monitor: compare each token transfer with the oldest expected token
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_token t;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                tokens_seen++;
                if (tokens_due.size() == 0) begin
                    report($sformatf("unexpected token kind %0d col %0d len %0d",
                                     o_token_kind, o_start_column, o_token_length));
                end else begin
                    t = tokens_due.pop_front();
                    if (o_token_kind !== t.kind)
                        report($sformatf("kind %0d, expected %0d", o_token_kind, t.kind));
                    if (o_start_column !== t.col)
                        report($sformatf("start column %0d, expected %0d", o_start_column, t.col));
                    if (o_token_length !== t.len)
                        report($sformatf("length %0d, expected %0d", o_token_length, t.len));
                    if (o_is_last !== t.last)
                        report($sformatf("is_last %0b, expected %0b", o_is_last, t.last));
                end
            end
            if (!long_hold_done && tokens_seen >= 40) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if ((tokens_seen / 80) % 3 == 2) begin
                i_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 59) == 0) hold_left = $urandom_range(8, 40);
                i_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    initial begin
        clear_scan();
        // directed lines
        put_line("x = a + 1.5e+3_dp");
        put_line("if (a .and. b) c=.5");
        put_line("3.eq.x 1.5f 1.d2 1.e 1.ex");
        put_line("5Hhello 2Hab 99999Hx 0H 3Hab");
        put_line({"'it''s' ", "\"dq\"", " 'open"});
        put_line({"b'101' z", "\"ff\"", " o'7' X'1"});
        put_line("(/ 1, 2 /) [a] x::y : ; % ** // /= == => <= >= <> ~");
        put_line("a . or  . b .x .. .a b.");
        put_line("1_4 1_ 2_k 1e 1e+ 1q-2 1.f");
        put_line("x ! comment 'x");
        put_line("$ bad after");
        put_line("1.2.3 9h");
        put_line("");
        put_line("abc");
        put_str("ab c");
        put_ch(8'd0);
        put_str("zz ignored");
        put_eol();
        put_str("1.e");
        put_ch(8'd255);
        put_ch(8'd128);
        put_eol();
        put_line("_z9 Z_ .5 5.");
        // random lines, mostly well-formed
        begin
            int base;
            base = src_chars.size();
            while (src_chars.size() - base < 135) put_random_line();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_chars.size() != 0 || i_valid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        $display("sent %0d characters in %0d lines, checked %0d tokens", chars_sent,
                 lines_built, tokens_seen);
        $display("covered all lexeme kinds, malformed tokens, null characters, stalls");
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("fortran_token_scanner regression: pass");
        end else begin
            $display("fortran_token_scanner regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for tokens");
        $display("fortran_token_scanner regression: fail");
        $finish;
    end

endmodule
